>>> hdl/packed_sample_bit_unpacker_macros.svh
// assertion macros for the packed sample bit unpacker
// used by the top level only, no other dependencies
`ifndef PACKED_SAMPLE_BIT_UNPACKER_MACROS_SVH
`define PACKED_SAMPLE_BIT_UNPACKER_MACROS_SVH

// checked at every edge outside reset
`define PBU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PBU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pbu_pkg.sv
// shared types, constants and helpers for the packed sample bit unpacker
// no dependencies
package pbu_pkg;

   localparam int MaxWidth  = 32;
   localparam int SampleW   = MaxWidth;
   localparam int ResW      = 6;
   localparam int CountW    = 16;
   localparam int ByteW     = 8;
   localparam int LbitsW    = 4;
   localparam int CsrIndexW = 1;
   localparam int CsrDataW  = 16;

   localparam logic [CsrIndexW-1:0] CsrBitResolution = 1'b0;
   localparam logic [CsrIndexW-1:0] CsrSampleCount   = 1'b1;

   localparam logic [ResW-1:0]   ResResetVal   = 6'd16;
   localparam logic [LbitsW-1:0] FullByteBits  = 4'd8;

   // per-block collection state
   typedef struct packed {
      logic [SampleW-1:0] partial;
      logic [ResW-1:0]    pbits;
      logic [CountW-1:0]  samples_left;
      logic               in_block;
   } blk_state_type;

   // bits of the current beat not yet consumed
   typedef struct packed {
      logic [ByteW-1:0]  bits;
      logic [LbitsW-1:0] count;
      logic              fresh;
   } byte_state_type;

   // what one step produces
   typedef struct packed {
      logic               emit;
      logic               done;
      logic [SampleW-1:0] sample;
      logic               run_end;
      logic               block_end;
   } step_out_type;

   // low n bits set, n from 0 to 8
   function automatic logic [ByteW-1:0] chunk_mask(input logic [LbitsW-1:0] n);
      logic [ByteW:0] m;
      m = ((ByteW+1)'(1) << n) - (ByteW+1)'(1);
      return m[ByteW-1:0];
   endfunction

endpackage

>>> hdl/pbu_step.sv
// one unpack step: takes one sample out of the current beat or absorbs its tail
// depends on pbu_pkg
module pbu_step import pbu_pkg::*; (
   input  logic [ResW-1:0]   res_raw,
   input  logic [CountW-1:0] count,
   input  blk_state_type     cur_blk,
   input  byte_state_type    cur_byte,
   output blk_state_type     nxt_blk,
   output byte_state_type    nxt_byte,
   output step_out_type      st
);

   logic [ResW-1:0]    res;
   logic               drop;
   blk_state_type      eff;
   logic [LbitsW-1:0]  lbits;
   logic [ResW-1:0]    need;
   logic [LbitsW-1:0]  n;
   logic [ByteW-1:0]   chunk;
   logic [ByteW-1:0]   rest_byte;
   logic [LbitsW-1:0]  rest_bits;
   logic [CountW-1:0]  samples_dec;
   logic               last_of_block;
   logic               more;

   always_comb begin
      res = (res_raw > ResW'(MaxWidth)) ? ResW'(MaxWidth) : res_raw;
      drop = cur_byte.fresh && ((res_raw == '0) || (!cur_blk.in_block && count == '0));

      // block start and discard of a partial that no longer fits
      eff = cur_blk;
      if (cur_byte.fresh && !cur_blk.in_block) begin
         eff.samples_left = count;
         eff.in_block     = 1'b1;
         eff.partial      = '0;
         eff.pbits        = '0;
      end
      if (cur_byte.fresh && eff.pbits >= res) begin
         eff.partial = '0;
         eff.pbits   = '0;
      end

      lbits         = cur_byte.fresh ? FullByteBits : cur_byte.count;
      need          = res - eff.pbits;
      n             = need[LbitsW-1:0];
      chunk         = cur_byte.bits & chunk_mask(n);
      rest_byte     = cur_byte.bits >> n;
      rest_bits     = lbits - n;
      samples_dec   = eff.samples_left - CountW'(1);
      last_of_block = (samples_dec == '0);
      more          = !last_of_block && ({2'b00, rest_bits} >= res);

      nxt_blk      = cur_blk;
      nxt_byte     = cur_byte;
      st.emit      = 1'b0;
      st.done      = 1'b1;
      st.sample    = eff.partial | (SampleW'(chunk) << eff.pbits);
      st.run_end   = !more;
      st.block_end = last_of_block;

      if (!drop) begin
         if ({2'b00, lbits} >= need) begin
            st.emit = 1'b1;
            if (last_of_block) begin
               // rest of the beat is thrown away
               nxt_blk = '0;
            end else if (more) begin
               nxt_blk.partial      = '0;
               nxt_blk.pbits        = '0;
               nxt_blk.samples_left = samples_dec;
               nxt_blk.in_block     = 1'b1;
               nxt_byte.bits        = rest_byte;
               nxt_byte.count       = rest_bits;
               nxt_byte.fresh       = 1'b0;
               st.done              = 1'b0;
            end else begin
               // tail of the beat starts the next sample
               nxt_blk.partial      = SampleW'(rest_byte);
               nxt_blk.pbits        = ResW'(rest_bits);
               nxt_blk.samples_left = samples_dec;
               nxt_blk.in_block     = 1'b1;
            end
         end else begin
            nxt_blk         = eff;
            nxt_blk.partial = eff.partial | (SampleW'(cur_byte.bits) << eff.pbits);
            nxt_blk.pbits   = eff.pbits + {2'b00, lbits};
         end
      end
   end

endmodule

>>> hdl/packed_sample_bit_unpacker.sv
// top level of the packed sample bit unpacker
// depends on pbu_pkg, pbu_step and packed_sample_bit_unpacker_macros.svh
//
// Payload bytes come in on req_ (one beat per byte) and unpacked samples leave
// on rsp_, one sample per beat, with run_end on the last sample of a byte and
// block_end on the last sample of a block. Samples are packed lsb first at
// bit_resolution bits (csr index 0, saturated at 32); sample_count (csr index 1)
// samples make one block, after which the rest of that byte is dropped.
// csr_ready is always high; write registers only while no byte is in flight.
// A byte is latched on acceptance and worked off one sample per cycle by the
// step logic while the output is free; each sample appears on rsp_ in the
// cycle after the step that forms it. A byte holds the step logic until its
// last sample is formed, or until it is absorbed or dropped if it gives none,
// so at resolutions of 8 or more a byte is taken every cycle while the output
// is free, and at widths below 8 a byte holds it while it gives each sample.
// When rsp_ready is low the sample waits in the output register, a step that
// would emit holds, and req_ready drops once the current byte cannot finish.
// Reset clears the block state and restores resolution 16 and count 0.
`include "packed_sample_bit_unpacker_macros.svh"

module packed_sample_bit_unpacker import pbu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteW-1:0]     req_payload_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SampleW-1:0]   rsp_sample_value,
   output logic                 rsp_run_end,
   output logic                 rsp_block_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   logic [ResW-1:0]    res_ff;
   logic [CountW-1:0]  count_ff;
   blk_state_type      blk_ff, blk_in;
   byte_state_type     byte_ff, byte_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SampleW-1:0] sample_ff;
   logic               run_end_ff;
   logic               block_end_ff;

   blk_state_type      nxt_blk;
   byte_state_type     nxt_byte;
   step_out_type       st;

   logic               out_free;
   logic               step_go;
   logic               byte_done;
   logic               accept;

   pbu_step u_step (
      .res_raw  (res_ff),
      .count    (count_ff),
      .cur_blk  (blk_ff),
      .cur_byte (byte_ff),
      .nxt_blk  (nxt_blk),
      .nxt_byte (nxt_byte),
      .st       (st)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      step_go   = busy_ff && (!st.emit || out_free);
      byte_done = step_go && st.done;
      req_ready = !busy_ff || byte_done;
      accept    = req_valid && req_ready;

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (byte_done) begin
         busy_in = 1'b0;
      end

      byte_in = byte_ff;
      if (accept) begin
         byte_in.bits  = req_payload_byte;
         byte_in.count = FullByteBits;
         byte_in.fresh = 1'b1;
      end else if (step_go) begin
         byte_in = nxt_byte;
      end

      blk_in = step_go ? nxt_blk : blk_ff;

      rsp_valid_in = rsp_valid_ff;
      if (step_go && st.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff       <= ResResetVal;
         count_ff     <= '0;
         blk_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CsrBitResolution) begin
            res_ff <= csr_data[ResW-1:0];
         end
         if (csr_valid && csr_index == CsrSampleCount) begin
            count_ff <= csr_data[CountW-1:0];
         end
         blk_ff       <= blk_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (step_go && st.emit) begin
         sample_ff    <= st.sample;
         run_end_ff   <= st.run_end;
         block_end_ff <= st.block_end;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = sample_ff;
   assign rsp_run_end      = run_end_ff;
   assign rsp_block_end    = block_end_ff;

   // an open block always has samples still due
   `PBU_ASSERT(a_open_block_has_samples, clock, reset, blk_ff.in_block |-> blk_ff.samples_left != '0, "open block with no samples left")

   // outside a block nothing is collected
   `PBU_ASSERT_ALWAYS(a_idle_block_clear, clock, !blk_ff.in_block |-> (blk_ff.pbits == '0 && blk_ff.partial == '0), "partial sample held outside a block")

   // a beat carried over between steps still has bits and an open block
   `PBU_ASSERT(a_carry_valid, clock, reset, (busy_ff && !byte_ff.fresh) |-> (byte_ff.count != '0 && blk_ff.in_block), "carried beat without bits or block")

   // a block end always closes the block
   `PBU_ASSERT(a_block_end_closes, clock, reset, (step_go && st.emit && st.block_end) |=> !blk_ff.in_block, "block end left block open")

endmodule

>>> tb/sv/tb_packed_sample_bit_unpacker.sv
`timescale 1ns / 1ps
// self-checking testbench for packed_sample_bit_unpacker: payload byte driver,
// sample monitor and bit-level unpacking predictor, all in one top module
// depends on pbu_pkg and the packed_sample_bit_unpacker rtl
module tb_packed_sample_bit_unpacker;
   import pbu_pkg::*;

   typedef struct packed {
      logic [SampleW-1:0] value;
      logic               run_end;
      logic               block_end;
   } sample_beat_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ByteW-1:0]     req_payload_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SampleW-1:0]   rsp_sample_value;
   logic                 rsp_run_end;
   logic                 rsp_block_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIndexW-1:0] csr_index = CsrBitResolution;
   logic [CsrDataW-1:0]  csr_data = '0;

   // payload bytes waiting for the driver, samples waiting for the dut
   logic [ByteW-1:0] byte_q[$];
   sample_beat_type  due_samples[$];

   int unsigned send_idle_pct = 10;
   int unsigned recv_idle_pct = 78;
   logic        req_taken = 1'b0;
   int unsigned mismatches = 0;

   // predictor copy of the registers and the block state
   logic [ResW-1:0]    res_cfg = ResResetVal;
   logic [CountW-1:0]  count_cfg = '0;
   logic [SampleW-1:0] acc = '0;
   int unsigned        acc_bits = 0;
   logic [CountW-1:0]  samples_due = '0;
   logic               in_blk = 1'b0;

   packed_sample_bit_unpacker uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_run_end      (rsp_run_end),
      .rsp_block_end    (rsp_block_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("packed_sample_bit_unpacker: mismatch");
      $finish;
   end

   // append one payload byte for the driver
   function automatic void queue_byte(input logic [ByteW-1:0] b);
      byte_q = {byte_q, b};
   endfunction

   // consume one payload byte lsb first and queue the samples it completes
   function automatic void unpack_byte(input logic [ByteW-1:0] payload);
      int unsigned      width;
      int unsigned      room;
      int unsigned      take;
      int unsigned      bits_left;
      logic [ByteW-1:0] rest;
      sample_beat_type  held;
      bit               have_held;
      width = res_cfg;
      have_held = 1'b0;
      held = '0;
      if (width == 0) return;
      if (width > MaxWidth) width = MaxWidth;
      if (!in_blk) begin
         if (count_cfg == 0) return;
         samples_due = count_cfg;
         in_blk = 1'b1;
         acc = '0;
         acc_bits = 0;
      end
      // resolution dropped below what is already collected
      if (acc_bits >= width) begin
         acc = '0;
         acc_bits = 0;
      end
      rest = payload;
      bits_left = ByteW;
      while (bits_left > 0 && samples_due > 0) begin
         room = width - acc_bits;
         take = (room < bits_left) ? room : bits_left;
         acc = acc | ((SampleW'(rest) & ((SampleW'(1) << take) - SampleW'(1))) << acc_bits);
         rest = rest >> take;
         bits_left = bits_left - take;
         acc_bits = acc_bits + take;
         if (acc_bits == width) begin
            if (have_held) due_samples = {due_samples, held};
            held = '{value: acc, run_end: 1'b0, block_end: 1'b0};
            have_held = 1'b1;
            samples_due = samples_due - 1'b1;
            acc = '0;
            acc_bits = 0;
         end
      end
      // block complete, rest of the byte is dropped
      if (samples_due == 0) begin
         held.block_end = 1'b1;
         in_blk = 1'b0;
         acc = '0;
         acc_bits = 0;
      end
      if (have_held) begin
         held.run_end = 1'b1;
         due_samples = {due_samples, held};
      end
   endfunction

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload_byte <= byte_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      sample_beat_type want;
      if (reset) begin
         req_taken <= 1'b0;
         res_cfg = ResResetVal;
         count_cfg = '0;
         acc = '0;
         acc_bits = 0;
         samples_due = '0;
         in_blk = 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (due_samples.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected sample beat: %h run_end %b block_end %b",
                           rsp_sample_value, rsp_run_end, rsp_block_end);
               mismatches++;
            end else begin
               want = due_samples.pop_front();
               if (rsp_sample_value !== want.value || rsp_run_end !== want.run_end ||
                   rsp_block_end !== want.block_end) begin
                  if (mismatches < 10)
                     $display("sample beat differs: expected %h/%b/%b, got %h/%b/%b",
                              want.value, want.run_end, want.block_end,
                              rsp_sample_value, rsp_run_end, rsp_block_end);
                  mismatches++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrBitResolution) res_cfg = csr_data[ResW-1:0];
            else count_cfg = csr_data[CountW-1:0];
         end
         if (req_valid && req_ready) unpack_byte(req_payload_byte);
      end
   end

   task automatic write_csr(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all bytes taken, all samples back, then let a byte with no sample retire
   task automatic wait_idle();
      do @(negedge clock); while (byte_q.size() != 0 || req_valid || due_samples.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned         width_eff;
      int unsigned         rem_bits;
      int unsigned         nbytes;
      int unsigned         random_bytes;
      logic [ResW-1:0]     res;
      logic [CountW-1:0]   cnt;
      logic [CsrDataW-1:0] data;
      random_bytes = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sample count still zero after reset: bytes give nothing
      queue_byte(8'hA5);
      queue_byte(8'h3C);
      wait_idle();
      write_csr(CsrSampleCount, 16'd1);
      // zero resolution, upper data bits ignored
      write_csr(CsrBitResolution, 16'hFFC0);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      wait_idle();
      // resolution above the maximum saturates to 32
      write_csr(CsrBitResolution, 16'h003F);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(8'hA5);
      queue_byte(8'h5A);
      wait_idle();
      // one-bit samples: eight per byte, tail of the last byte dropped
      write_csr(CsrBitResolution, 16'd1);
      write_csr(CsrSampleCount, 16'd10);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      wait_idle();
      // count rewritten mid-block has no effect until the next block
      write_csr(CsrBitResolution, 16'd32);
      write_csr(CsrSampleCount, 16'd2);
      repeat (4) queue_byte(ByteW'($urandom));
      wait_idle();
      write_csr(CsrSampleCount, 16'hFFFF);
      write_csr(CsrSampleCount, 16'd5);
      repeat (4) queue_byte(ByteW'($urandom));
      wait_idle();
      // resolution lowered below the bits already collected
      write_csr(CsrBitResolution, 16'd12);
      queue_byte(8'h96);
      wait_idle();
      write_csr(CsrBitResolution, 16'd5);
      repeat (4) queue_byte(ByteW'($urandom));
      wait_idle();

      while (random_bytes < 500) begin
         if (random_bytes < 170) begin
            send_idle_pct = 10;
            recv_idle_pct = 78;
         end else if (random_bytes < 340) begin
            send_idle_pct = 78;
            recv_idle_pct = 10;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
               0: res = '0;
               1: res = ResW'($urandom_range(63, MaxWidth + 1));
               2: res = ResW'(1);
               3: res = ResW'(MaxWidth);
               default: res = ResW'($urandom_range(MaxWidth, 1));
            endcase
            data = CsrDataW'($urandom);
            data[ResW-1:0] = res;
            write_csr(CsrBitResolution, data);
         end
         if ($urandom_range(2) != 0) begin
            if (in_blk && $urandom_range(4) == 0) write_csr(CsrSampleCount, 16'hFFFF);
            case ($urandom_range(9))
               0: cnt = '0;
               1: cnt = CountW'($urandom_range(64, 13));
               default: cnt = CountW'($urandom_range(12, 1));
            endcase
            write_csr(CsrSampleCount, cnt);
         end
         width_eff = (res_cfg > MaxWidth) ? MaxWidth : res_cfg;
         // mostly finish the open block and run a few whole ones, else a short burst
         if ($urandom_range(4) != 0 && width_eff != 0) begin
            rem_bits = 0;
            if (in_blk)
               rem_bits = samples_due * width_eff - ((acc_bits < width_eff) ? acc_bits : 0);
            nbytes = (rem_bits + 7) / 8 + $urandom_range(2) * ((count_cfg * width_eff + 7) / 8);
            if (nbytes > 48) nbytes = 48;
            if (nbytes == 0) nbytes = 1;
         end else begin
            nbytes = $urandom_range(6, 1);
         end
         if (width_eff != 0 && (in_blk || count_cfg != 0)) random_bytes += nbytes;
         repeat (nbytes) begin
            case ($urandom_range(9))
               0: queue_byte(8'h00);
               1: queue_byte(8'hFF);
               default: queue_byte(ByteW'($urandom));
            endcase
         end
         wait_idle();
      end

      if (mismatches == 0 && due_samples.size() == 0) begin
         $display("packed_sample_bit_unpacker: match");
      end else begin
         $display("packed_sample_bit_unpacker: mismatch");
      end
      $finish;
   end

endmodule
